>>> hdl/mi3_pkg.sv
`default_nettype none
package mi3_pkg;

  localparam int FixW  = 32;
  localparam int AdjW  = 64;
  // Determinant is a sum of three 96-bit products, so 98 signed bits hold it.
  localparam int DetW  = 98;
  localparam int MagW  = DetW - 1;
  // Dividend is |adj| * 2^33 + |det|.
  localparam int NumW  = DetW;
  localparam int QBits = 32;
  localparam int RemW  = NumW + QBits;
  // Operand register, overflow check, then one quotient bit per stage.
  localparam int DivLat = QBits + 2;
  // Cofactor (2), determinant (3), magnitude and singular check (1).
  localparam int PreLat = 6;
  localparam int Depth  = PreLat + DivLat;
  localparam int NumEl  = 9;

  localparam logic [63:0]      ThreshReset = 64'd281;
  localparam logic [FixW-1:0]  PosMax      = 32'h7FFF_FFFF;
  localparam logic [FixW-1:0]  NegMaxMag   = 32'h8000_0000;

  typedef logic signed [FixW-1:0] fix_t;
  typedef logic signed [AdjW-1:0] adj_t;
  typedef logic signed [DetW-1:0] det_t;

  typedef struct packed {
    fix_t a_r1c1;
    fix_t a_r2c1;
    fix_t a_r3c1;
    fix_t a_r1c2;
    fix_t a_r2c2;
    fix_t a_r3c2;
    fix_t a_r1c3;
    fix_t a_r2c3;
    fix_t a_r3c3;
  } in_item_t;

  typedef struct packed {
    fix_t inv_r1c1;
    fix_t inv_r2c1;
    fix_t inv_r3c1;
    fix_t inv_r1c2;
    fix_t inv_r2c2;
    fix_t inv_r3c2;
    fix_t inv_r1c3;
    fix_t inv_r2c3;
    fix_t inv_r3c3;
    logic invertible;
  } out_item_t;

  // Per-item control that rides alongside the dividers.
  typedef struct packed {
    logic [NumEl-1:0] neg;
    logic             singular;
  } side_t;

endpackage
`default_nettype wire

>>> hdl/matrix_inverse_3x3.sv
`default_nettype none
// Channel   Ports                          Direction  Moves
// input     in_valid, in_ready, in_data    in         one 3x3 matrix, Q16.16
// result    out_valid, out_ready, out_data out        nine inverse terms + flag
// config    cfg_we, cfg_wdata              in         singular threshold
//
// One matrix enters per cycle whenever the pipeline is not frozen.
// Most of the pipeline is the nine restoring dividers, one quotient bit per stage.
// Reset clears the valid bits and loads the threshold with 281.
// The whole pipeline advances together; it freezes when the output register
// holds a result that is not taken, so nothing is dropped or repeated.
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [63:0] cfg_wdata
);

  logic             en;
  logic [63:0]      thr_r;
  logic [Depth-1:0] vld_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        out_data_nxt;

  adj_t  adj_c [NumEl];
  fix_t  col1  [3];
  det_t  det;
  adj_t  adj_d [NumEl];

  logic [MagW-1:0]  dmag_nxt;
  logic [MagW-1:0]  dmag_r;
  logic [AdjW-1:0]  cm_r [NumEl];
  side_t            side_nxt;
  side_t            side_r [DivLat+1];
  logic [QBits-1:0] q   [NumEl];
  logic             ovf [NumEl];
  fix_t             res [NumEl];

  // The pipeline moves whenever the output register is free or being drained.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThreshReset;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[Depth-2:0], in_valid};
      out_valid_r <= vld_r[Depth-1];
    end
  end

  mi3_cof u_cof (
    .clk    (clk),
    .en     (en),
    .a_i    (in_data),
    .adj_o  (adj_c),
    .col1_o (col1)
  );

  mi3_det u_det (
    .clk    (clk),
    .en     (en),
    .col1_i (col1),
    .adj_i  (adj_c),
    .det_o  (det),
    .adj_o  (adj_d)
  );

  // Magnitude of the determinant and the singular test. A zero determinant
  // is always singular, even with a zero threshold.
  always_comb begin
    dmag_nxt = det[DetW-1] ? MagW'(-det) : MagW'(det);
    side_nxt.singular = (dmag_nxt[MagW-1:64] == '0) &&
                        ((dmag_nxt[63:0] < thr_r) || (dmag_nxt[63:0] == '0));
    for (int k = 0; k < NumEl; k++) begin
      side_nxt.neg[k] = adj_d[k][AdjW-1] ^ det[DetW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag_r    <= dmag_nxt;
      side_r[0] <= side_nxt;
      for (int k = 0; k < NumEl; k++) begin
        cm_r[k] <= adj_d[k][AdjW-1] ? AdjW'(-adj_d[k]) : AdjW'(adj_d[k]);
      end
      for (int j = 1; j <= DivLat; j++) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  for (genvar k = 0; k < NumEl; k++) begin : g_div
    mi3_div u_div (
      .clk    (clk),
      .en     (en),
      .cm_i   (cm_r[k]),
      .dmag_i (dmag_r),
      .q_o    (q[k]),
      .ovf_o  (ovf[k])
    );
  end

  // Sign and saturation; the singular case forces every term to zero.
  always_comb begin
    for (int k = 0; k < NumEl; k++) begin
      if (side_r[DivLat].singular) begin
        res[k] = '0;
      end else if (side_r[DivLat].neg[k]) begin
        res[k] = (ovf[k] || q[k] > NegMaxMag) ? fix_t'(NegMaxMag) : fix_t'(-q[k]);
      end else begin
        res[k] = (ovf[k] || q[k][QBits-1]) ? fix_t'(PosMax) : fix_t'(q[k]);
      end
    end
    out_data_nxt.inv_r1c1   = res[0];
    out_data_nxt.inv_r2c1   = res[1];
    out_data_nxt.inv_r3c1   = res[2];
    out_data_nxt.inv_r1c2   = res[3];
    out_data_nxt.inv_r2c2   = res[4];
    out_data_nxt.inv_r3c2   = res[5];
    out_data_nxt.inv_r1c3   = res[6];
    out_data_nxt.inv_r2c3   = res[7];
    out_data_nxt.inv_r3c3   = res[8];
    out_data_nxt.invertible = !side_r[DivLat].singular;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A frozen pipeline keeps its valid bits.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

  // An accepted transfer enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted transfer lost at entry");

  // A singular result carries zeros on the diagonal, the last term included.
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.invertible |->
      out_data.inv_r3c3 == '0 && out_data.inv_r1c1 == '0 && out_data.inv_r2c2 == '0)
    else $error("singular result not cleared");

endmodule
`default_nettype wire

>>> hdl/mi3_cof.sv
`default_nettype none
module mi3_cof import mi3_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  in_item_t a_i,
  output adj_t     adj_o [NumEl],
  output fix_t     col1_o [3]
);

  adj_t pp_r [NumEl];
  adj_t pq_r [NumEl];
  adj_t pp_nxt [NumEl];
  adj_t pq_nxt [NumEl];
  fix_t c1_r [3];
  adj_t adj_r [NumEl];
  fix_t c2_r [3];

  // Each cofactor is pp - pq, signs of the adjugate already folded in.
  always_comb begin
    pp_nxt[0] = a_i.a_r3c3 * a_i.a_r2c2;  pq_nxt[0] = a_i.a_r3c2 * a_i.a_r2c3;
    pp_nxt[1] = a_i.a_r3c1 * a_i.a_r2c3;  pq_nxt[1] = a_i.a_r3c3 * a_i.a_r2c1;
    pp_nxt[2] = a_i.a_r3c2 * a_i.a_r2c1;  pq_nxt[2] = a_i.a_r3c1 * a_i.a_r2c2;
    pp_nxt[3] = a_i.a_r3c2 * a_i.a_r1c3;  pq_nxt[3] = a_i.a_r3c3 * a_i.a_r1c2;
    pp_nxt[4] = a_i.a_r3c3 * a_i.a_r1c1;  pq_nxt[4] = a_i.a_r3c1 * a_i.a_r1c3;
    pp_nxt[5] = a_i.a_r3c1 * a_i.a_r1c2;  pq_nxt[5] = a_i.a_r3c2 * a_i.a_r1c1;
    pp_nxt[6] = a_i.a_r2c3 * a_i.a_r1c2;  pq_nxt[6] = a_i.a_r2c2 * a_i.a_r1c3;
    pp_nxt[7] = a_i.a_r2c1 * a_i.a_r1c3;  pq_nxt[7] = a_i.a_r2c3 * a_i.a_r1c1;
    pp_nxt[8] = a_i.a_r2c2 * a_i.a_r1c1;  pq_nxt[8] = a_i.a_r2c1 * a_i.a_r1c2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r  <= pp_nxt;
      pq_r  <= pq_nxt;
      c1_r[0] <= a_i.a_r1c1;
      c1_r[1] <= a_i.a_r2c1;
      c1_r[2] <= a_i.a_r3c1;
      for (int k = 0; k < NumEl; k++) begin
        adj_r[k] <= pp_r[k] - pq_r[k];
      end
      c2_r <= c1_r;
    end
  end

  assign adj_o  = adj_r;
  assign col1_o = c2_r;

endmodule
`default_nettype wire

>>> hdl/mi3_det.sv
`default_nettype none
module mi3_det import mi3_pkg::*; (
  input  logic clk,
  input  logic en,
  input  fix_t col1_i [3],
  input  adj_t adj_i [NumEl],
  output det_t det_o,
  output adj_t adj_o [NumEl]
);

  logic signed [AdjW-1:0] ph_r [3];
  logic signed [AdjW:0]   pl_r [3];
  det_t                   term_r [3];
  det_t                   det_r;
  adj_t                   adj1_r [NumEl];
  adj_t                   adj2_r [NumEl];
  adj_t                   adj3_r [NumEl];

  // a * adj is split into a * adj[63:32] and a * adj[31:0] to keep the
  // multipliers near 32 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ph_r[j] <= col1_i[j] * $signed(adj_i[3*j][AdjW-1:32]);
        pl_r[j] <= col1_i[j] * $signed({1'b0, adj_i[3*j][31:0]});
        term_r[j] <= (det_t'(ph_r[j]) <<< 32) + det_t'(pl_r[j]);
      end
      det_r  <= term_r[0] + term_r[1] + term_r[2];
      adj1_r <= adj_i;
      adj2_r <= adj1_r;
      adj3_r <= adj2_r;
    end
  end

  assign det_o = det_r;
  assign adj_o = adj3_r;

endmodule
`default_nettype wire

>>> hdl/mi3_div.sv
`default_nettype none
module mi3_div import mi3_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [AdjW-1:0]   cm_i,
  input  logic [MagW-1:0]   dmag_i,
  output logic [QBits-1:0]  q_o,
  output logic              ovf_o
);

  logic [NumW-1:0]  n_r;
  logic [NumW-1:0]  d0_r;
  logic [RemW-1:0]  rem_r [QBits];
  logic [NumW-1:0]  dd_r  [QBits];
  logic [QBits-1:0] q_r   [QBits+1];
  logic             ovf_r [QBits+1];

  // Rounded quotient: floor((2*cm*2^32 + d) / (2*d)).
  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= NumW'({cm_i, 33'b0}) + NumW'(dmag_i);
      d0_r <= NumW'({dmag_i, 1'b0});
      ovf_r[0]  <= RemW'(n_r) >= (RemW'(d0_r) << QBits);
      rem_r[0]  <= RemW'(n_r);
      dd_r[0]   <= d0_r;
      q_r[0]    <= '0;
    end
  end

  for (genvar i = 0; i < QBits; i++) begin : g_step
    logic [RemW-1:0] sh;
    logic            ge;
    assign sh = RemW'(dd_r[i]) << (QBits - 1 - i);
    assign ge = rem_r[i] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1]   <= {q_r[i][QBits-2:0], ge};
        ovf_r[i+1] <= ovf_r[i];
      end
    end
    if (i < QBits - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= ge ? rem_r[i] - sh : rem_r[i];
          dd_r[i+1]  <= dd_r[i];
        end
      end
    end
  end

  assign q_o   = q_r[QBits];
  assign ovf_o = ovf_r[QBits];

endmodule
`default_nettype wire
